// ----- hdl/phe_pkg.sv -----
// ----------------------------------------------------------------------------
// phe_pkg
// Shared types, constants and helper functions of the package header id
// extractor.
// ----------------------------------------------------------------------------
package phe_pkg;

    // Default sizes of the content-id field and the captured id
    localparam int MAX_ID_LEN_DEF   = 32;
    localparam int FIELD_OFFSET_DEF = 48;
    localparam int FIELD_LEN_DEF    = 36;

    // Byte position counter saturates at its all-ones value
    localparam int          POS_W     = 7;
    localparam logic [6:0]  POS_MAX   = 7'd127;
    localparam int          MAGIC_LEN = 4;

    localparam logic [7:0] CHAR_NUL  = 8'h00;
    localparam logic [7:0] CHAR_DASH = 8'h2D;
    localparam logic [7:0] CHAR_US   = 8'h5F;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_SHORT   = 3'd1,
        ST_MAGIC   = 3'd2,
        ST_NO_DASH = 3'd3,
        ST_NO_US   = 3'd4,
        ST_INVALID = 3'd5
    } status_t;

    // Content-id field parse phase
    typedef enum logic [1:0] {
        PH_SEEK    = 2'd0,
        PH_CAPTURE = 2'd1,
        PH_DONE    = 2'd2
    } phase_t;

    // Emission sequencer states
    typedef enum logic [1:0] {
        EM_IDLE  = 2'd0,
        EM_FETCH = 2'd1,
        EM_LOAD  = 2'd2,
        EM_HOLD  = 2'd3
    } emit_state_t;

    // Hand-off from the scanner to the emitter at the end of a header
    typedef struct packed {
        logic    start;
        status_t status;
    } run_start_t;

    // Expected magic byte at offsets 0 to 3
    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0:    b = 8'h7F;
            2'd1:    b = 8'h50;
            2'd2:    b = 8'h4B;
            default: b = 8'h47;
        endcase
        return b;
    endfunction

    // Letters, digits and dash are legal id characters
    function automatic logic allowed_char(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) ||
               ((c >= 8'h61) && (c <= 8'h7A)) ||
               ((c >= 8'h30) && (c <= 8'h39)) ||
               (c == CHAR_DASH);
    endfunction

endpackage

// ----- hdl/phe_if.sv -----
// ----------------------------------------------------------------------------
// phe_if
// Valid/ready channels of the extractor: header bytes in, id results out.
// ----------------------------------------------------------------------------
interface phe_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] header_byte;
    logic       end_of_header;

    modport source (output valid, output header_byte, output end_of_header, input ready);
    modport sink   (input valid, input header_byte, input end_of_header, output ready);
endinterface

interface phe_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] id_char;
    logic       run_last;

    modport source (output valid, output status, output id_char, output run_last, input ready);
    modport sink   (input valid, input status, input id_char, input run_last, output ready);
endinterface

// ----- hdl/package_header_id_extractor_core.sv -----
// ----------------------------------------------------------------------------
// package_header_id_extractor_core
// Header byte stream in; content-id characters or one error status out.
//
//   Channel     Dir  Payload                          Transaction
//   byte_in     in   header_byte, end_of_header       one header byte
//   result_out  out  status, id_char, run_last        one id char or error
//
// One header byte is taken per cycle while no result run is in progress.
// After the last byte, each id character goes through an id store read, an
// output register load and a handshake, one character at a time through the
// single read port of the id store; an error result is shown in the cycle after the last byte.
// No input is taken until the run's final result is delivered.
// Reset clears parse state and the sequencer; the id store is not cleared.
// ----------------------------------------------------------------------------
module package_header_id_extractor_core
    import phe_pkg::*;
#(
    parameter int MAX_ID_LEN   = MAX_ID_LEN_DEF,
    parameter int FIELD_OFFSET = FIELD_OFFSET_DEF,
    parameter int FIELD_LEN    = FIELD_LEN_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    phe_byte_if.sink    byte_in,
    phe_result_if.source result_out
);

    localparam int CW = $clog2(MAX_ID_LEN + 2);
    localparam int AW = (MAX_ID_LEN > 1) ? $clog2(MAX_ID_LEN) : 1;

    logic          accept;
    logic          idle;
    logic          we, re;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]    wdata, rdata;
    run_start_t    run;
    logic [CW-1:0] run_len;

    assign byte_in.ready = idle;
    assign accept        = byte_in.valid && idle;

    // Byte parser
    phe_scan #(
        .MAX_ID_LEN   (MAX_ID_LEN),
        .FIELD_OFFSET (FIELD_OFFSET),
        .FIELD_LEN    (FIELD_LEN)
    ) u_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .header_byte   (byte_in.header_byte),
        .end_of_header (byte_in.end_of_header),
        .we            (we),
        .waddr         (waddr),
        .wdata         (wdata),
        .run           (run),
        .run_len       (run_len)
    );

    // Id store
    phe_ram #(
        .WIDTH (8),
        .DEPTH (MAX_ID_LEN)
    ) u_id_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Result sequencer
    phe_emit #(
        .MAX_ID_LEN (MAX_ID_LEN)
    ) u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .run        (run),
        .run_len    (run_len),
        .idle       (idle),
        .re         (re),
        .raddr      (raddr),
        .rdata      (rdata),
        .out_valid  (result_out.valid),
        .out_ready  (result_out.ready),
        .out_status (result_out.status),
        .out_char   (result_out.id_char),
        .out_last   (result_out.run_last)
    );

endmodule

// ----- hdl/phe_ram.sv -----
// ----------------------------------------------------------------------------
// phe_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module phe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/phe_scan.sv -----
// ----------------------------------------------------------------------------
// phe_scan
// Per-byte header parser: magic check, content-id field scan, id capture
// into the id store, and final status on the last header byte.
// ----------------------------------------------------------------------------
module phe_scan
    import phe_pkg::*;
#(
    parameter int MAX_ID_LEN   = MAX_ID_LEN_DEF,
    parameter int FIELD_OFFSET = FIELD_OFFSET_DEF,
    parameter int FIELD_LEN    = FIELD_LEN_DEF,
    localparam int CW          = $clog2(MAX_ID_LEN + 2),
    localparam int AW          = (MAX_ID_LEN > 1) ? $clog2(MAX_ID_LEN) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    header_byte,
    input  logic          end_of_header,
    output logic          we,
    output logic [AW-1:0] waddr,
    output logic [7:0]    wdata,
    output run_start_t    run,
    output logic [CW-1:0] run_len
);

    localparam int FIELD_END = FIELD_OFFSET + FIELD_LEN;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             magic_good_reg, magic_good_next;
    phase_t           phase_reg, phase_next;
    logic             closed_reg, closed_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             invalid_reg, invalid_next;
    logic             in_field;
    status_t          code;

    // State update for one header byte
    always_comb
    begin
        pos_next        = (pos_reg < POS_MAX) ? pos_reg + POS_W'(1) : pos_reg;
        magic_good_next = magic_good_reg;
        phase_next      = phase_reg;
        closed_next     = closed_reg;
        count_next      = count_reg;
        invalid_next    = invalid_reg;
        we              = 1'b0;
        in_field        = (int'(pos_reg) >= FIELD_OFFSET) && (int'(pos_reg) < FIELD_END);

        if ((pos_reg < POS_W'(MAGIC_LEN)) && (header_byte != magic_byte(pos_reg[1:0])))
        begin
            magic_good_next = 1'b0;
        end

        if (in_field && !closed_reg)
        begin
            if (header_byte == CHAR_NUL)
            begin
                closed_next = 1'b1;
            end
            else
            begin
                case (phase_reg)
                    PH_SEEK:
                    begin
                        if (header_byte == CHAR_DASH)
                        begin
                            phase_next = PH_CAPTURE;
                        end
                    end
                    PH_CAPTURE:
                    begin
                        if (header_byte == CHAR_US)
                        begin
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            we = accept && (count_reg < CW'(MAX_ID_LEN));
                            if (count_reg < CW'(MAX_ID_LEN + 1))
                            begin
                                count_next = count_reg + CW'(1);
                            end
                            if (!allowed_char(header_byte))
                            begin
                                invalid_next = 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    assign waddr = count_reg[AW-1:0];
    assign wdata = header_byte;

    // Final status, by precedence
    always_comb
    begin
        if (int'(pos_next) < FIELD_END)
            code = ST_SHORT;
        else if (!magic_good_next)
            code = ST_MAGIC;
        else if (phase_next == PH_SEEK)
            code = ST_NO_DASH;
        else if (phase_next == PH_CAPTURE)
            code = ST_NO_US;
        else if ((count_next == '0) || (count_next > CW'(MAX_ID_LEN)) || invalid_next)
            code = ST_INVALID;
        else
            code = ST_OK;
    end

    assign run.start  = accept && end_of_header;
    assign run.status = code;
    assign run_len    = count_next;

    // Parse state; cleared after the last byte of a header
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            magic_good_reg <= 1'b1;
            phase_reg      <= PH_SEEK;
            closed_reg     <= 1'b0;
            count_reg      <= '0;
            invalid_reg    <= 1'b0;
        end
        else if (accept)
        begin
            if (end_of_header)
            begin
                pos_reg        <= '0;
                magic_good_reg <= 1'b1;
                phase_reg      <= PH_SEEK;
                closed_reg     <= 1'b0;
                count_reg      <= '0;
                invalid_reg    <= 1'b0;
            end
            else
            begin
                pos_reg        <= pos_next;
                magic_good_reg <= magic_good_next;
                phase_reg      <= phase_next;
                closed_reg     <= closed_next;
                count_reg      <= count_next;
                invalid_reg    <= invalid_next;
            end
        end
    end

endmodule

// ----- hdl/phe_emit.sv -----
// ----------------------------------------------------------------------------
// phe_emit
// Result sequencer: reads the id store one entry at a time into the output
// register, or presents a single error result.
// ----------------------------------------------------------------------------
module phe_emit
    import phe_pkg::*;
#(
    parameter int MAX_ID_LEN = MAX_ID_LEN_DEF,
    localparam int CW        = $clog2(MAX_ID_LEN + 2),
    localparam int AW        = (MAX_ID_LEN > 1) ? $clog2(MAX_ID_LEN) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  run_start_t    run,
    input  logic [CW-1:0] run_len,
    output logic          idle,
    output logic          re,
    output logic [AW-1:0] raddr,
    input  logic [7:0]    rdata,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [2:0]    out_status,
    output logic [7:0]    out_char,
    output logic          out_last
);

    emit_state_t   state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] len_reg;
    logic [2:0]    status_reg;
    logic [7:0]    char_reg;
    logic          last_reg;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= EM_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // Next state and read control
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        re         = 1'b0;
        unique case (state_reg)
            EM_IDLE:
            begin
                if (run.start)
                begin
                    idx_next   = '0;
                    state_next = (run.status == ST_OK) ? EM_FETCH : EM_HOLD;
                end
            end
            EM_FETCH:
            begin
                re         = 1'b1;
                state_next = EM_LOAD;
            end
            EM_LOAD:
            begin
                state_next = EM_HOLD;
            end
            EM_HOLD:
            begin
                if (out_ready)
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = last_reg ? EM_IDLE : EM_FETCH;
                end
            end
            default: state_next = EM_IDLE;
        endcase
    end

    assign raddr = idx_reg[AW-1:0];

    // Output register and run length
    always_ff @(posedge clk)
    begin
        if ((state_reg == EM_IDLE) && run.start)
        begin
            len_reg    <= run_len;
            status_reg <= run.status;
            char_reg   <= '0;
            last_reg   <= 1'b1;
        end
        else if (state_reg == EM_LOAD)
        begin
            status_reg <= ST_OK;
            char_reg   <= rdata;
            last_reg   <= (idx_reg + CW'(1)) == len_reg;
        end
    end

    assign idle       = (state_reg == EM_IDLE);
    assign out_valid  = (state_reg == EM_HOLD);
    assign out_status = status_reg;
    assign out_char   = char_reg;
    assign out_last   = last_reg;

endmodule

// ----- hdl/phe_checker.sv -----
// ----------------------------------------------------------------------------
// phe_checker
// Port-level assertions on the extractor, bound to the top level.
// ----------------------------------------------------------------------------
module phe_checker
    import phe_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       in_last,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] out_status,
    input logic [7:0] out_char,
    input logic       out_run_last
);

    // No byte is taken while a result is pending
    a_no_input_during_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready while a result is pending");

    // The last header byte starts a run
    a_run_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_last) |=> !in_ready)
        else $error("input still ready after the last header byte");

    // An error result is a single, final, zero-character result
    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_status != ST_OK)) |-> (out_run_last && (out_char == 8'h00)))
        else $error("malformed error result");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(out_status) && $stable(out_char) && $stable(out_run_last)))
        else $error("stalled result changed");

endmodule

bind package_header_id_extractor_core phe_checker u_phe_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (byte_in.valid),
    .in_ready     (byte_in.ready),
    .in_last      (byte_in.end_of_header),
    .out_valid    (result_out.valid),
    .out_ready    (result_out.ready),
    .out_status   (result_out.status),
    .out_char     (result_out.id_char),
    .out_run_last (result_out.run_last)
);

// ----- verif/phe_id_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// phe_id_checker
// Watches both channels of the header id extractor. Every accepted header
// byte goes through a local model of the magic check and content-id scan.
// The results each header should produce are queued, and every accepted
// result is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module phe_id_checker
    import phe_pkg::*;
#(
    parameter int MAX_ID_LEN   = MAX_ID_LEN_DEF,
    parameter int FIELD_OFFSET = FIELD_OFFSET_DEF,
    parameter int FIELD_LEN    = FIELD_LEN_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    phe_byte_if     byte_mon,
    phe_result_if   res_mon,
    output int      fail_count,
    output int      open_results,
    output int      results_checked
);

    localparam int          LEN_W     = $clog2(MAX_ID_LEN + 2);
    localparam int          FIELD_END = FIELD_OFFSET + FIELD_LEN;
    localparam logic [31:0] HDR_MAGIC = 32'h7F504B47;
    localparam int          PRINT_CAP = 40;

    typedef struct packed {
        status_t    status;
        logic [7:0] id_char;
        logic       run_last;
    } id_result_t;

    // Scan state of the header in progress
    logic [POS_W-1:0] scan_pos;
    logic             magic_ok;
    logic             field_cut;
    logic             bad_char;
    phase_t           scan_phase;
    logic [7:0]       id_buf [MAX_ID_LEN];
    logic [LEN_W-1:0] id_len;

    id_result_t id_expect_q [$];
    int         mismatch_total;
    int         checked_total;

    // Letters (either case), digits and dash may appear in an id
    function automatic logic is_id_char(input logic [7:0] c);
        logic [7:0] folded;
        folded = c | 8'h20;
        return (folded >= 8'h61 && folded <= 8'h7A) ||
               (c >= 8'h30 && c <= 8'h39) || c == CHAR_DASH;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_total++;
        if (mismatch_total <= PRINT_CAP)
            $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task automatic clear_scan();
        scan_pos   = '0;
        magic_ok   = 1'b1;
        field_cut  = 1'b0;
        bad_char   = 1'b0;
        scan_phase = PH_SEEK;
        id_len     = '0;
    endtask

    // One header byte: magic check, field scan, and the run on the last byte
    task automatic scan_header_byte(input logic [7:0] c, input logic hdr_last);
        int         p;
        status_t    run_status;
        id_result_t r;
        p = scan_pos;
        if (p < MAGIC_LEN && c != HDR_MAGIC[8*(MAGIC_LEN-1-p) +: 8])
            magic_ok = 1'b0;
        if (p >= FIELD_OFFSET && p < FIELD_END && !field_cut)
        begin
            if (c == CHAR_NUL)
                field_cut = 1'b1;
            else if (scan_phase == PH_SEEK)
            begin
                if (c == CHAR_DASH)
                    scan_phase = PH_CAPTURE;
            end
            else if (scan_phase == PH_CAPTURE)
            begin
                if (c == CHAR_US)
                    scan_phase = PH_DONE;
                else
                begin
                    if (id_len < MAX_ID_LEN)
                        id_buf[id_len] = c;
                    if (id_len <= MAX_ID_LEN)
                        id_len++;
                    if (!is_id_char(c))
                        bad_char = 1'b1;
                end
            end
        end
        if (scan_pos != POS_MAX)
            scan_pos++;
        if (!hdr_last)
            return;

        // Error precedence follows the order of the checks below
        if (scan_pos < FIELD_END)
            run_status = ST_SHORT;
        else if (!magic_ok)
            run_status = ST_MAGIC;
        else if (scan_phase == PH_SEEK)
            run_status = ST_NO_DASH;
        else if (scan_phase == PH_CAPTURE)
            run_status = ST_NO_US;
        else if (id_len == 0 || id_len > MAX_ID_LEN || bad_char)
            run_status = ST_INVALID;
        else
            run_status = ST_OK;

        if (run_status != ST_OK)
        begin
            r.status   = run_status;
            r.id_char  = 8'h00;
            r.run_last = 1'b1;
            id_expect_q.push_back(r);
        end
        else
        begin
            for (int k = 0; k < id_len; k++)
            begin
                r.status   = ST_OK;
                r.id_char  = id_buf[k];
                r.run_last = (k == id_len - 1);
                id_expect_q.push_back(r);
            end
        end
        clear_scan();
    endtask

    // Predict on accepted bytes, compare on accepted results
    always @(posedge clk or negedge rst_n)
    begin
        id_result_t want;
        if (!rst_n)
        begin
            clear_scan();
            id_expect_q.delete();
            mismatch_total  = 0;
            checked_total   = 0;
            fail_count      <= 0;
            open_results    <= 0;
            results_checked <= 0;
        end
        else
        begin
            if (byte_mon.valid === 1'b1 && byte_mon.ready === 1'b1)
                scan_header_byte(byte_mon.header_byte, byte_mon.end_of_header);
            if (res_mon.valid === 1'b1 && res_mon.ready === 1'b1)
            begin
                checked_total++;
                if (id_expect_q.size() == 0)
                    report_mismatch($sformatf("result with none pending: status %0d char 0x%0h",
                                              res_mon.status, res_mon.id_char));
                else
                begin
                    want = id_expect_q.pop_front();
                    if (res_mon.status !== want.status)
                        report_mismatch($sformatf("result %0d status got %0d expected %0d",
                                                  checked_total, res_mon.status, want.status));
                    if (res_mon.id_char !== want.id_char)
                        report_mismatch($sformatf("result %0d id_char got 0x%0h expected 0x%0h",
                                                  checked_total, res_mon.id_char, want.id_char));
                    if (res_mon.run_last !== want.run_last)
                        report_mismatch($sformatf("result %0d run_last got %0b expected %0b",
                                                  checked_total, res_mon.run_last,
                                                  want.run_last));
                end
            end
            fail_count      <= mismatch_total;
            open_results    <= id_expect_q.size();
            results_checked <= checked_total;
        end
    end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams package headers into the id extractor: one header for each status
// code, the longest id in a header past the position limit, and an over-long
// id offered while the result side is held off. Random idling runs on both
// channels except in the closing header. The checker module does the scoring.
// ----------------------------------------------------------------------------
module testbench;
    import phe_pkg::*;

    localparam int LONG_HOLD     = 200;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 20;

    logic       clk;
    logic       rst_n;
    int         mismatches;
    int         open_results;
    int         results_checked;
    int         bytes_sent;
    int         headers_sent;
    int         idle_cycles;
    bit         send_calm;
    bit         recv_calm;
    bit         long_hold_req;
    logic [7:0] hdr_q [$];

    phe_byte_if   byte_ch ();
    phe_result_if result_ch ();

    package_header_id_extractor_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_ch),
        .result_out (result_ch)
    );

    phe_id_checker u_id_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .byte_mon        (byte_ch),
        .res_mon         (result_ch),
        .fail_count      (mismatches),
        .open_results    (open_results),
        .results_checked (results_checked)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Legal id character, dash now and then
    function automatic logic [7:0] pick_id_char();
        case ($urandom_range(0, 6))
            0, 1:    return 8'h41 + 8'($urandom_range(0, 25));
            2, 3:    return 8'h61 + 8'($urandom_range(0, 25));
            4, 5:    return 8'h30 + 8'($urandom_range(0, 9));
            default: return CHAR_DASH;
        endcase
    endfunction

    // Non-NUL byte that is neither letter, digit, dash nor underscore
    function automatic logic [7:0] pick_bad_char();
        case ($urandom_range(0, 5))
            0:       return 8'($urandom_range(8'h01, 8'h2C));
            1:       return 8'($urandom_range(8'h2E, 8'h2F));
            2:       return 8'($urandom_range(8'h3A, 8'h40));
            3:       return 8'($urandom_range(8'h5B, 8'h5E));
            4:       return 8'h60;
            default: return 8'($urandom_range(8'h7B, 8'hFF));
        endcase
    endfunction

    // Any byte but NUL and dash, so the field stays open and unanchored
    function automatic logic [7:0] pick_seek_byte();
        logic [7:0] v;
        v = 8'($urandom_range(1, 254));
        if (v >= CHAR_DASH)
            v = v + 8'd1;
        return v;
    endfunction

    // Assemble a header: magic, padding, content-id field, tail
    task automatic build_header(input int bad_magic_at, input int prefix_len,
                                input bit has_dash, input int id_len, input bit has_us,
                                input int bad_at, input int nul_at, input int tail_len);
        logic [7:0] fld [$];
        hdr_q.delete();
        for (int i = 0; i < MAGIC_LEN; i++)
        begin
            if (i == bad_magic_at)
                hdr_q.push_back(magic_byte(2'(i)) ^ 8'($urandom_range(1, 255)));
            else
                hdr_q.push_back(magic_byte(2'(i)));
        end
        while (hdr_q.size() < FIELD_OFFSET_DEF)
            hdr_q.push_back(8'($urandom_range(0, 255)));

        repeat (prefix_len)
            fld.push_back(pick_seek_byte());
        if (has_dash)
            fld.push_back(CHAR_DASH);
        for (int i = 0; i < id_len; i++)
            fld.push_back(i == bad_at ? pick_bad_char() : pick_id_char());
        if (has_us)
            fld.push_back(CHAR_US);
        // Filler must not supply the separator that the header lacks
        while (fld.size() < FIELD_LEN_DEF)
        begin
            if (!has_dash)
                fld.push_back(pick_seek_byte());
            else if (!has_us)
                fld.push_back(pick_id_char());
            else
                fld.push_back(8'($urandom_range(0, 255)));
        end
        while (fld.size() > FIELD_LEN_DEF)
            void'(fld.pop_back());
        if (nul_at >= 0 && nul_at < FIELD_LEN_DEF)
            fld[nul_at] = CHAR_NUL;
        foreach (fld[i])
            hdr_q.push_back(fld[i]);
        repeat (tail_len)
            hdr_q.push_back(8'($urandom_range(0, 255)));
    endtask

    // One byte transaction, with an optional idle burst ahead of it
    task automatic push_byte(input logic [7:0] b, input logic hdr_last);
        if (!send_calm && $urandom_range(0, 5) == 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        byte_ch.valid         <= 1'b1;
        byte_ch.header_byte   <= b;
        byte_ch.end_of_header <= hdr_last;
        do
            @(posedge clk);
        while (byte_ch.ready !== 1'b1);
        bytes_sent++;
    endtask

    task automatic send_header();
        foreach (hdr_q[i])
            push_byte(hdr_q[i], i == hdr_q.size() - 1);
        headers_sent++;
    endtask

    // Hold the sender until every expected result has been delivered
    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (open_results != 0);
    endtask

    // Result side: random stall bursts, plus one long hold-off on request
    initial
    begin
        result_ch.ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (!recv_calm && $urandom_range(0, 4) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (byte_ch.valid === 1'b1 && byte_ch.ready === 1'b1) ||
            (result_ch.valid === 1'b1 && result_ch.ready === 1'b1))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, open_results);
            $display("[package_header_id_extractor_core] ERROR");
            $finish;
        end
    end

    // Stimulus and verdict
    initial
    begin
        byte_ch.valid         <= 1'b0;
        byte_ch.header_byte   <= 8'h00;
        byte_ch.end_of_header <= 1'b0;
        rst_n                 <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // One-byte header (short and bad magic at once)
        hdr_q.delete();
        hdr_q.push_back(CHAR_NUL);
        send_header();
        // Bad magic outranks a missing dash
        build_header(3, 0, 1'b0, 0, 1'b0, -1, -1, 0);
        send_header();
        // Missing dash
        build_header(-1, 3, 1'b0, 0, 1'b0, -1, -1, 0);
        send_header();
        wait_drained();

        // Longest id in a header past the position limit, then an over-long
        // id offered while the result side is held off
        build_header(-1, 2, 1'b1, MAX_ID_LEN_DEF, 1'b1, -1, -1, 46);
        send_header();
        long_hold_req = 1'b1;
        build_header(-1, 0, 1'b1, MAX_ID_LEN_DEF + 1, 1'b1, -1, -1, 0);
        send_header();
        wait_drained();

        // Closing stretch without idling: missing underscore
        send_calm = 1'b1;
        recv_calm = 1'b1;
        build_header(-1, 2, 1'b1, 10, 1'b0, -1, -1, 0);
        send_header();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Streamed %0d headers (%0d bytes): every status code, a %0d-char id,",
                 headers_sent, bytes_sent, MAX_ID_LEN_DEF);
        $display("long result hold-off and drained pauses; %0d results checked, %0d mismatches",
                 results_checked, mismatches);
        if (mismatches == 0 && open_results == 0)
            $display("[package_header_id_extractor_core] OK");
        else
            $display("[package_header_id_extractor_core] ERROR");
        $finish;
    end

endmodule
